// ===== sv/lmt_pkg.sv =====
// Shared types and constants for the 3x3 local-mean threshold block.
// No dependencies; used by the interfaces, the window unit and the top level.
package lmt_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // Configuration registers
  localparam int CFG_W        = 11;
  localparam int ROW_W        = 11;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Input beat kinds
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Result queue depth
  localparam int OUTQ_DEPTH = 4;

  // Per-item control that travels with a pixel into the window unit
  typedef struct packed {
    logic emit;       // this beat produces a result
    logic row_top;    // row above the result pixel is inside the image
    logic row_bot;    // row below is inside the image
    logic col_left;   // column to the left is inside the image
    logic col_right;  // column to the right is inside the image
    logic last;       // result is the frame's final pixel
  } lmt_ctrl_t;

  // Height register to rows in use
  function automatic logic [ROW_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    if (v == '0) return ROW_W'(1);
    if (32'(v) > 32'(HEIGHT_LIMIT)) return ROW_W'(HEIGHT_LIMIT);
    return ROW_W'(v);
  endfunction

endpackage

// ===== sv/lmt_if.sv =====
// Valid/ready stream interfaces for pixel beats in and threshold beats out.
// Depends on lmt_pkg for the default pixel width.
interface lmt_in_if #(
  parameter int PIXEL_BITS = lmt_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, cmd, pixel, input ready);
  modport sink   (input valid, cmd, pixel, output ready);
endinterface

interface lmt_out_if;
  logic valid;
  logic ready;
  logic above_mean;
  logic last_in_frame;

  modport source (output valid, above_mean, last_in_frame, input ready);
  modport sink   (input valid, above_mean, last_in_frame, output ready);
endinterface

// ===== sv/lmt_window.sv =====
// 3x3 window registers and the border-masked mean comparison.
// Depends on lmt_pkg (lmt_ctrl_t); fed by the line buffer in the top level.
module lmt_window #(
  parameter int PIXEL_BITS = lmt_pkg::PIXEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    shift,
  input  logic [PIXEL_BITS-1:0]   up,
  input  logic [PIXEL_BITS-1:0]   mid,
  input  logic [PIXEL_BITS-1:0]   px,
  input  lmt_pkg::lmt_ctrl_t      ctrl,
  input  logic                    clear_req,
  output logic                    res_valid,
  output logic                    res_above,
  output logic                    res_last
);

  localparam int SUM_W = PIXEL_BITS + 4;

  logic [PIXEL_BITS-1:0] win [9];
  logic                  clear_win;
  logic                  s2_valid;
  lmt_pkg::lmt_ctrl_t    s2_ctrl;
  logic [2:0]            rowv;
  logic [2:0]            colv;
  logic [SUM_W-1:0]      sum;
  logic [3:0]            cnt;
  logic [SUM_W-1:0]      prod;

  // Window shift: left two columns move, right column from line buffer and input.
  // After a frame ends the old columns read as zero.
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3+0] <= clear_win ? '0 : win[r*3+1];
        win[r*3+1] <= clear_win ? '0 : win[r*3+2];
      end
      win[2] <= up;
      win[5] <= mid;
      win[8] <= px;
      s2_ctrl <= ctrl;
    end
  end

  // Control: frame-restart flag and result-stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_win <= 1'b1;
      s2_valid  <= 1'b0;
    end else begin
      s2_valid <= shift & ctrl.emit;
      if (clear_req) begin
        clear_win <= 1'b1;
      end else if (shift) begin
        clear_win <= ctrl.last;
      end
    end
  end

  // Masked sum and count over neighbours inside the image
  assign rowv = {s2_ctrl.row_bot, 1'b1, s2_ctrl.row_top};
  assign colv = {s2_ctrl.col_right, 1'b1, s2_ctrl.col_left};

  always_comb begin
    sum = '0;
    cnt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rowv[r] && colv[c]) begin
          sum = sum + SUM_W'(win[r*3+c]);
          cnt = cnt + 4'd1;
        end
      end
    end
  end

  // center * count > sum, exact
  assign prod = SUM_W'(win[4]) * SUM_W'(cnt);

  assign res_valid = s2_valid;
  assign res_above = prod > sum;
  assign res_last  = s2_ctrl.last;

endmodule

// ===== sv/local_mean_threshold_3x3.sv =====
// Streaming 3x3 local-mean threshold over pixel beats in raster order: one result
// bit per pixel, set when the pixel exceeds its neighbourhood mean with
// out-of-image neighbours excluded. A result appears once W+1 further beats
// (pixels or flush ticks) have entered and then passes the line buffer read,
// window and result queue registers. Throughput is one beat per clock while
// the result queue has room, set by the single-port-read/single-port-write
// line memory that holds both previous rows side by side (MAX_WIDTH entries
// of two pixels). The memory needs no clearing pass; configuration writes
// restart the frame and keep its contents. Depends on lmt_pkg, lmt_if and lmt_window.
module local_mean_threshold_3x3 #(
  parameter int MAX_WIDTH  = lmt_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = lmt_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lmt_pkg::APB_AW-1:0]   paddr,
  input  logic [lmt_pkg::APB_DW-1:0]   pwdata,
  output logic [lmt_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  lmt_in_if.sink                       pix_in,
  lmt_out_if.source                    res_out
);

  localparam int CFG_W  = lmt_pkg::CFG_W;
  localparam int ROW_W  = lmt_pkg::ROW_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int QPTR_W = $clog2(lmt_pkg::OUTQ_DEPTH);
  localparam int QCNT_W = $clog2(lmt_pkg::OUTQ_DEPTH + 1);
  localparam int QSUM_W = QCNT_W + 1;

  typedef struct packed {
    logic above_mean;
    logic last_in_frame;
  } res_t;

  function automatic logic [WCNT_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    if (v == '0) return WCNT_W'(1);
    if (32'(v) > 32'(MAX_WIDTH)) return WCNT_W'(MAX_WIDTH);
    return WCNT_W'(v);
  endfunction

  // Configuration
  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;
  logic [WCNT_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic              cfg_wr;

  // Position counters
  logic [COL_W-1:0]  in_column;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic              accept;
  logic              emit_now;
  logic              col_end;
  logic              out_col_end;
  logic              out_row_end;
  logic              last_now;
  logic [PIXEL_BITS-1:0] px_in;

  // Line buffer stage
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] line_rd;
  logic                    s1_valid;
  lmt_pkg::lmt_ctrl_t      s1_ctrl;
  logic [PIXEL_BITS-1:0]   s1_px;
  logic [COL_W-1:0]        s1_col;
  logic                    s1_fwd;
  logic [PIXEL_BITS-1:0]   s1_fwd_up;
  logic [PIXEL_BITS-1:0]   s1_fwd_mid;
  logic [PIXEL_BITS-1:0]   s1_up;
  logic [PIXEL_BITS-1:0]   s1_mid;

  // Result path
  logic              res_valid;
  logic              res_above;
  logic              res_last;
  res_t              outq [lmt_pkg::OUTQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_cnt;
  logic              push;
  logic              pop;
  logic [QSUM_W-1:0] q_load;

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == lmt_pkg::REG_HEIGHT) ? lmt_pkg::APB_DW'(height_reg)
                                                    : lmt_pkg::APB_DW'(width_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= CFG_W'(lmt_pkg::WIDTH_RESET);
      height_reg <= CFG_W'(lmt_pkg::HEIGHT_RESET);
      w_eff      <= clamp_width(CFG_W'(lmt_pkg::WIDTH_RESET));
      h_eff      <= lmt_pkg::clamp_height(CFG_W'(lmt_pkg::HEIGHT_RESET));
    end else if (cfg_wr) begin
      if (paddr[2] == lmt_pkg::REG_WIDTH) begin
        width_reg <= pwdata[CFG_W-1:0];
        w_eff     <= clamp_width(pwdata[CFG_W-1:0]);
      end else begin
        height_reg <= pwdata[CFG_W-1:0];
        h_eff      <= lmt_pkg::clamp_height(pwdata[CFG_W-1:0]);
      end
    end
  end

  // Input side: position of the incoming beat and of the result it releases
  assign accept      = pix_in.valid & pix_in.ready;
  assign emit_now    = (in_row > ROW_W'(1)) || (in_row == ROW_W'(1) && in_column != '0);
  assign col_end     = (WCNT_W'(in_column) + WCNT_W'(1)) == w_eff;
  assign out_col_end = (WCNT_W'(out_col) + WCNT_W'(1)) == w_eff;
  assign out_row_end = (out_row + ROW_W'(1)) == h_eff;
  assign last_now    = emit_now & out_col_end & out_row_end;
  assign px_in       = (pix_in.cmd == lmt_pkg::CMD_FLUSH) ? '0 : PIXEL_BITS'(pix_in.pixel);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_column <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (accept) begin
      if (last_now) begin
        in_column <= '0;
        in_row    <= '0;
        out_col   <= '0;
        out_row   <= '0;
      end else begin
        in_column <= col_end ? '0 : in_column + COL_W'(1);
        if (col_end) begin
          in_row <= in_row + ROW_W'(1);
        end
        if (emit_now) begin
          out_col <= out_col_end ? '0 : out_col + COL_W'(1);
          if (out_col_end) begin
            out_row <= out_row + ROW_W'(1);
          end
        end
      end
    end
  end

  // Line memory: entry holds {row above, center row} for one column
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[in_column];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= {s1_mid, s1_px};
    end
  end

  // Stage 1 payload; forward when the previous beat writes the column being read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px      <= px_in;
      s1_col     <= in_column;
      s1_fwd     <= s1_valid && (s1_col == in_column);
      s1_fwd_up  <= s1_mid;
      s1_fwd_mid <= s1_px;
      s1_ctrl    <= '{emit:      emit_now,
                      row_top:   out_row != '0,
                      row_bot:   !out_row_end,
                      col_left:  out_col != '0,
                      col_right: !out_col_end,
                      last:      last_now};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  assign s1_up  = s1_fwd ? s1_fwd_up  : line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
  assign s1_mid = s1_fwd ? s1_fwd_mid : line_rd[PIXEL_BITS-1:0];

  lmt_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (s1_valid),
    .up        (s1_up),
    .mid       (s1_mid),
    .px        (s1_px),
    .ctrl      (s1_ctrl),
    .clear_req (cfg_wr),
    .res_valid (res_valid),
    .res_above (res_above),
    .res_last  (res_last)
  );

  // Result queue; input is held off when queued plus in-flight results fill it
  assign push   = res_valid;
  assign pop    = res_out.valid & res_out.ready;
  assign q_load = QSUM_W'(q_cnt) + QSUM_W'(s1_valid & s1_ctrl.emit) + QSUM_W'(res_valid);
  assign pix_in.ready = q_load < QSUM_W'(lmt_pkg::OUTQ_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      outq[wr_ptr] <= '{above_mean: res_above, last_in_frame: res_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   q_cnt <= q_cnt + QCNT_W'(1);
        2'b01:   q_cnt <= q_cnt - QCNT_W'(1);
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  assign res_out.valid         = q_cnt != '0;
  assign res_out.above_mean    = outq[rd_ptr].above_mean;
  assign res_out.last_in_frame = outq[rd_ptr].last_in_frame;

endmodule

// ===== sv/lmt_checker.sv =====
// Port-level checks for local_mean_threshold_3x3, attached by bind.
// Depends only on the top level's port signals.
module lmt_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic above_mean,
  input logic last_in_frame
);

  // Result queue starts empty after reset
  a_empty_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result beat offered right after reset");

  // Input is held off only when results are waiting to be taken
  a_backpressure_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A stalled result beat stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(above_mean) && $stable(last_in_frame))
    else $error("result payload changed while stalled");

endmodule

bind local_mean_threshold_3x3 lmt_checker u_lmt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (pix_in.ready),
  .out_valid     (res_out.valid),
  .out_ready     (res_out.ready),
  .above_mean    (res_out.above_mean),
  .last_in_frame (res_out.last_in_frame)
);
